### hdl/maximal_munch_tokenizer_macros.svh
// ----------------------------------------------------------------------------
// Tokenizer assertion macros
// Shared property wrappers; every assertion is clocked on clk and gated by reset.
// ----------------------------------------------------------------------------
`ifndef MAXIMAL_MUNCH_TOKENIZER_MACROS_SVH
`define MAXIMAL_MUNCH_TOKENIZER_MACROS_SVH

// same-cycle implication
`define MMT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MMT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/mmt_pkg.sv
// ----------------------------------------------------------------------------
// mmt_pkg
// Token record, scan modes, kind codes and lexeme tables.
// ----------------------------------------------------------------------------
`default_nettype none
package mmt_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_INT,
		MODE_FLOAT,
		MODE_STR,
		MODE_STR_ESC,
		MODE_PUNCT
	} mode_t;

	localparam logic [5:0] KIND_END         = 6'd0;
	localparam logic [5:0] KIND_UNDEF       = 6'd1;
	localparam logic [5:0] KIND_KW_FIRST    = 6'd2;
	localparam logic [5:0] KIND_IDENT       = 6'd27;
	localparam logic [5:0] KIND_INT         = 6'd28;
	localparam logic [5:0] KIND_FLOAT       = 6'd29;
	localparam logic [5:0] KIND_STRING      = 6'd30;

	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_DOT    = 8'h2E;

	localparam int KW_COUNT = 25;
	localparam int KW_CHARS = 6;

	// keyword text, right-justified, first char in the highest used byte
	localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
		48'("let"), 48'("mut"), 48'("fn"), 48'("if"), 48'("else"), 48'("while"),
		48'("for"), 48'("as"), 48'("return"), 48'("extern"), 48'("true"),
		48'("false"), 48'("nil"), 48'("i8"), 48'("i16"), 48'("i32"), 48'("i64"),
		48'("u8"), 48'("u16"), 48'("u32"), 48'("u64"), 48'("f32"), 48'("f64"),
		48'("bool"), 48'("char")
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{
		3'd3, 3'd3, 3'd2, 3'd2, 3'd4, 3'd5, 3'd3, 3'd2, 3'd6, 3'd6, 3'd4,
		3'd5, 3'd3, 3'd2, 3'd3, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
		3'd4, 3'd4
	};

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] line;
		logic [15:0] column;
		logic [31:0] offset;
		logic [15:0] length;
		logic        last;
	} tok_t;

	// front-to-queue push bundle
	typedef struct packed {
		logic [1:0] count;
		tok_t       tok0;
		tok_t       tok1;
	} push_t;

	// single-byte punctuation kind, 0 when the byte is not punctuation
	function automatic logic [5:0] punct_single(input logic [7:0] b);
		logic [5:0] k;
		unique case (b)
			8'h28: k = 6'd32; 8'h29: k = 6'd33; 8'h7B: k = 6'd34; 8'h7D: k = 6'd35;
			8'h5B: k = 6'd36; 8'h5D: k = 6'd37; 8'h2C: k = 6'd38; 8'h2E: k = 6'd39;
			8'h2D: k = 6'd40; 8'h2B: k = 6'd41; 8'h3B: k = 6'd42; 8'h2F: k = 6'd43;
			8'h2A: k = 6'd44; 8'h21: k = 6'd46; 8'h3D: k = 6'd48; 8'h3C: k = 6'd50;
			8'h3E: k = 6'd52; 8'h25: k = 6'd53; 8'h26: k = 6'd55; 8'h7C: k = 6'd57;
			8'h5E: k = 6'd58; 8'h7E: k = 6'd59; 8'h3F: k = 6'd60; 8'h3A: k = 6'd61;
			default: k = 6'd0;
		endcase
		return k;
	endfunction

	// kinds whose byte may start a two-byte lexeme
	function automatic logic can_pair(input logic [5:0] k);
		return k == 6'd40 || k == 6'd46 || k == 6'd48 || k == 6'd50 ||
			k == 6'd52 || k == 6'd55 || k == 6'd57;
	endfunction

	// two-byte kind from pending single kind and second byte, 0 if none
	function automatic logic [5:0] punct_pair(input logic [5:0] k, input logic [7:0] b);
		logic [5:0] r;
		r = 6'd0;
		if (k == 6'd40 && b == 8'h3E) r = 6'd31;
		if (k == 6'd46 && b == 8'h3D) r = 6'd45;
		if (k == 6'd48 && b == 8'h3D) r = 6'd47;
		if (k == 6'd50 && b == 8'h3D) r = 6'd49;
		if (k == 6'd52 && b == 8'h3D) r = 6'd51;
		if (k == 6'd55 && b == 8'h26) r = 6'd54;
		if (k == 6'd57 && b == 8'h7C) r = 6'd56;
		return r;
	endfunction

endpackage
`default_nettype wire

### hdl/mmt_scan.sv
// ----------------------------------------------------------------------------
// mmt_scan
// Front end: takes one byte a beat, tracks position, emits up to two tokens.
// ----------------------------------------------------------------------------
`default_nettype none
module mmt_scan import mmt_pkg::*; #(
	parameter int POSITION_BITS   = 16,
	parameter int KEYWORD_MAX_LEN = 6
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_input,
	output push_t           push
);

	localparam int IW = $clog2(KEYWORD_MAX_LEN);
	localparam logic [POSITION_BITS-1:0] POS_LIMIT = '1;

	mode_t                      mode_q;
	logic [5:0]                 kind_q;
	logic [15:0]                len_q;
	logic [POSITION_BITS-1:0]   pline_q, pcol_q, cline_q, ccol_q;
	logic [31:0]                poff_q, coff_q;
	logic [7:0]                 prefix_q [KEYWORD_MAX_LEN];

	mode_t                      mode_d;
	logic [5:0]                 kind_d;
	logic [15:0]                len_d;
	logic [POSITION_BITS-1:0]   pline_d, pcol_d, cline_d, ccol_d;
	logic [31:0]                poff_d, coff_d;
	logic                       pfx_we;
	logic [IW-1:0]              pfx_idx;
	tok_t                       tok [2];
	logic [1:0]                 n;
	logic [5:0]                 ident_kind;

	function automatic logic [15:0] sat16(input logic [POSITION_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic tok_t mk(input logic [5:0] k, input logic [POSITION_BITS-1:0] l,
		input logic [POSITION_BITS-1:0] c, input logic [31:0] o, input logic [15:0] len);
		tok_t t;
		t.kind   = k;
		t.line   = sat16(l);
		t.column = sat16(c);
		t.offset = o;
		t.length = len;
		t.last   = 1'b0;
		return t;
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
	endfunction
	function automatic logic is_digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction
	function automatic logic is_space(input logic [7:0] b);
		return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	// keyword lookup over the stored prefix
	always_comb begin
		logic [47:0] w;
		w = '0;
		for (int i = 0; i < KW_CHARS; i++)
			if (16'(i) < len_q) w = {w[39:0], prefix_q[i]};
		ident_kind = KIND_IDENT;
		for (int k = KW_COUNT - 1; k >= 0; k--)
			if (len_q == 16'(KW_LEN[k]) && w == KW_TEXT[k])
				ident_kind = KIND_KW_FIRST + 6'(k);
	end

	always_comb begin
		logic       done;
		logic [5:0] pk, sk, fk;
		logic       fv;
		mode_d  = mode_q;  kind_d = kind_q;  len_d = len_q;
		pline_d = pline_q; pcol_d = pcol_q;  poff_d = poff_q;
		cline_d = cline_q; ccol_d = ccol_q;  coff_d = coff_q;
		pfx_we  = 1'b0;
		pfx_idx = len_q[IW-1:0];
		tok[0]  = '0;
		tok[1]  = '0;
		n       = 2'd0;
		done    = 1'b0;
		pk      = punct_pair(kind_q, in_byte);
		sk      = punct_single(in_byte);
		// pending token as flush would emit it
		fv = 1'b1;
		unique case (mode_q)
			MODE_IDENT:               fk = ident_kind;
			MODE_INT:                 fk = KIND_INT;
			MODE_FLOAT:               fk = KIND_FLOAT;
			MODE_STR, MODE_STR_ESC:   fk = KIND_UNDEF;
			MODE_PUNCT:               fk = kind_q;
			default: begin
				fk = KIND_END;
				fv = 1'b0;
			end
		endcase
		if (accept) begin
			if (end_of_input) begin
				if (fv) begin
					tok[n[0]] = mk(fk, pline_q, pcol_q, poff_q, len_q);
					n = n + 2'd1;
				end
				tok[n[0]] = mk(KIND_END, cline_q, ccol_q, coff_q, 16'd0);
				n = n + 2'd1;
				mode_d = MODE_IDLE;
			end else if (in_byte != CH_CR) begin
				unique case (mode_q)
					MODE_IDENT: if (is_alpha(in_byte) || is_digit(in_byte)) begin
						pfx_we = len_q < 16'(KEYWORD_MAX_LEN);
						done = 1'b1;
					end
					MODE_INT: if (is_digit(in_byte)) begin
						done = 1'b1;
					end else if (in_byte == CH_DOT) begin
						done = 1'b1;
						mode_d = MODE_FLOAT;
						kind_d = KIND_FLOAT;
					end
					MODE_FLOAT: done = is_digit(in_byte);
					MODE_STR: begin
						done = 1'b1;
						if (in_byte == CH_BSLASH) begin
							mode_d = MODE_STR_ESC;
						end else if (in_byte == CH_QUOTE) begin
							tok[n[0]] = mk(KIND_STRING, pline_q, pcol_q, poff_q,
								(len_q == 16'hFFFF) ? len_q : len_q + 16'd1);
							n = n + 2'd1;
							mode_d = MODE_IDLE;
						end
					end
					MODE_STR_ESC: begin
						done = 1'b1;
						mode_d = MODE_STR;
					end
					MODE_PUNCT: if (pk != 6'd0) begin
						tok[n[0]] = mk(pk, pline_q, pcol_q, poff_q, 16'd2);
						n = n + 2'd1;
						mode_d = MODE_IDLE;
						done = 1'b1;
					end
					default: mode_d = MODE_IDLE;
				endcase
				if (done && mode_q != MODE_PUNCT && len_q != 16'hFFFF)
					len_d = len_q + 16'd1;
				if (!done) begin
					if (fv) begin
						tok[n[0]] = mk(fk, pline_q, pcol_q, poff_q, len_q);
						n = n + 2'd1;
					end
					mode_d = MODE_IDLE;
					if (!is_space(in_byte)) begin
						if (is_alpha(in_byte) || is_digit(in_byte) || in_byte == CH_QUOTE ||
							(sk != 6'd0 && can_pair(sk))) begin
							len_d   = 16'd1;
							pline_d = cline_q;
							pcol_d  = ccol_q;
							poff_d  = coff_q;
							if (is_alpha(in_byte)) begin
								mode_d = MODE_IDENT; kind_d = KIND_IDENT;
								pfx_we = 1'b1; pfx_idx = '0;
							end else if (is_digit(in_byte)) begin
								mode_d = MODE_INT; kind_d = KIND_INT;
							end else if (in_byte == CH_QUOTE) begin
								mode_d = MODE_STR; kind_d = KIND_STRING;
							end else begin
								mode_d = MODE_PUNCT; kind_d = sk;
							end
						end else begin
							tok[n[0]] = mk((sk != 6'd0) ? sk : KIND_UNDEF, cline_q, ccol_q,
								coff_q, 16'd1);
							n = n + 2'd1;
						end
					end
				end
				// position advance
				coff_d = coff_q + 32'd1;
				if (in_byte == CH_LF) begin
					if (cline_q != POS_LIMIT) cline_d = cline_q + 1'b1;
					ccol_d = POSITION_BITS'(1);
				end else if (ccol_q != POS_LIMIT) begin
					ccol_d = ccol_q + 1'b1;
				end
			end
		end
		if (n == 2'd1) tok[0].last = 1'b1;
		if (n == 2'd2) tok[1].last = 1'b1;
		push.count = n;
		push.tok0  = tok[0];
		push.tok1  = tok[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			kind_q  <= KIND_END;
			len_q   <= '0;
			pline_q <= POSITION_BITS'(1);
			pcol_q  <= POSITION_BITS'(1);
			poff_q  <= '0;
			cline_q <= POSITION_BITS'(1);
			ccol_q  <= POSITION_BITS'(1);
			coff_q  <= '0;
		end else begin
			mode_q  <= mode_d;
			kind_q  <= kind_d;
			len_q   <= len_d;
			pline_q <= pline_d;
			pcol_q  <= pcol_d;
			poff_q  <= poff_d;
			cline_q <= cline_d;
			ccol_q  <= ccol_d;
			coff_q  <= coff_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pfx_we) prefix_q[pfx_idx] <= in_byte;
	end

endmodule
`default_nettype wire

### hdl/mmt_queue.sv
// ----------------------------------------------------------------------------
// mmt_queue
// Back end: four-entry token queue, up to two pushes and, while out_ready is high, one pop a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "maximal_munch_tokenizer_macros.svh"
module mmt_queue import mmt_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       space_ok,
	output logic       out_valid,
	input  wire logic  out_ready,
	output tok_t       out_tok
);

	tok_t       ent_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = cnt_q != 3'd0;
	assign out_tok   = ent_q[rd_q];
	assign space_ok  = cnt_q <= 3'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push.count;
			rd_q  <= rd_q + 2'(pop);
			cnt_q <= cnt_q + 3'(push.count) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) ent_q[wr_q] <= push.tok0;
		if (push.count == 2'd2) ent_q[wr_q + 2'd1] <= push.tok1;
	end

	`MMT_ASSERT_NOW(a_no_overflow, push.count != 2'd0, cnt_q <= 3'd2, "push into full queue")
	`MMT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= 3'd4, "queue count out of range")
	`MMT_ASSERT_NEXT(a_pop_only, pop && push.count == 2'd0, cnt_q == $past(cnt_q) - 3'd1, "pop count slip")

endmodule
`default_nettype wire

### hdl/maximal_munch_tokenizer.sv
// ----------------------------------------------------------------------------
// maximal_munch_tokenizer
// Longest-match tokenizer: source bytes in, token records out.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  s_*     | in  | tdata[7:0] in_byte; tlast end_of_input
//  m_*     | out | tdata kind/line/column/offset/length; tlast last_of_run
//
//  One byte is taken per ready cycle; each byte yields zero, one or two tokens.
//  The scanner state registers on each accepted byte, so bytes go back to back.
//  Tokens drain one per cycle while m_tready is high, from a 4-entry queue;
//  s_tready drops above two entries, so a two-token byte can stall the next.
//  arst_n clears mode, counters and queue pointers; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module maximal_munch_tokenizer import mmt_pkg::*; #(
	parameter int POSITION_BITS   = 16,
	parameter int KEYWORD_MAX_LEN = 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire logic        s_tlast,   // end_of_input
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [5:0] token_kind, [21:6] start_line, [37:22] start_column,
	// [69:38] start_offset, [85:70] token_length, [87:86] zero
	output logic [87:0]      m_tdata,
	output logic             m_tlast    // last_of_run
);

	push_t push;
	tok_t  head;
	logic  space_ok;

	assign s_tready = space_ok;

	// front: byte classification and token assembly
	mmt_scan #(
		.POSITION_BITS  (POSITION_BITS),
		.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (s_tvalid && space_ok),
		.in_byte     (s_tdata),
		.end_of_input(s_tlast),
		.push        (push)
	);

	// back: token queue toward the output beat
	mmt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space_ok (space_ok),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_tok  (head)
	);

	assign m_tdata = {2'b00, head.length, head.offset, head.column, head.line, head.kind};
	assign m_tlast = head.last;

endmodule
`default_nettype wire
